FILE: rtl/core/kbt_pkg.sv
// Shared constants, codes and types of the keyed block transposition.
// No dependencies; kbt_rank, kbt_emit and the top level refer to it by scoped names.
package kbt_pkg;

  localparam int unsigned MAX_KEY   = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_KEY);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned LETTERS_W = 40;
  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned CFG_DW    = LETTERS_W;
  localparam int unsigned DATA_W    = 8;

  localparam logic [DATA_W-1:0] PAD_CHAR = 8'h26;

  localparam logic [CFG_AW-1:0] CFG_KEY_LEN    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LETTERS_LO = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LETTERS_HI = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_DIRECTION  = 2'd3;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RANK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              is_end;
    logic              pad;
    logic [DATA_W-1:0] data;
  } emit_item_t;

  typedef struct packed {
    logic dec;
    logic last_blk;
  } emit_ctl_t;

endpackage

FILE: rtl/core/kbt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module kbt_ram #(
  parameter int unsigned DW = 8,
  parameter int unsigned AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/kbt_rank.sv
// Column rank of one key position, zero based, over the active key length.
// Depends on kbt_pkg.
module kbt_rank (
  input  logic [2*kbt_pkg::LETTERS_W-1:0] letters,
  input  logic [kbt_pkg::CNT_W-1:0]       key_len,
  input  logic [kbt_pkg::IDX_W-1:0]       idx,
  output logic [kbt_pkg::IDX_W-1:0]       rank
);

  logic [kbt_pkg::LETTER_W-1:0] lj;
  logic [kbt_pkg::CNT_W-1:0]    acc;

  assign lj = letters[idx * kbt_pkg::LETTER_W +: kbt_pkg::LETTER_W];

  always_comb begin
    logic [kbt_pkg::LETTER_W-1:0] li;
    acc = '0;
    for (int i = 0; i < kbt_pkg::MAX_KEY; i++) begin
      li = letters[i * kbt_pkg::LETTER_W +: kbt_pkg::LETTER_W];
      if ((kbt_pkg::CNT_W'(i) < key_len) &&
          ((li < lj) || ((li == lj) && (kbt_pkg::IDX_W'(i) < idx)))) begin
        acc = acc + kbt_pkg::CNT_W'(1);
      end
    end
  end

  assign rank = acc[kbt_pkg::IDX_W-1:0];

endmodule

FILE: rtl/core/kbt_emit.sv
// Result stage: decrypt truncation, one-beat lookahead for the last mark, output register.
// Depends on kbt_pkg.
module kbt_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kbt_pkg::emit_item_t         item,
  input  kbt_pkg::emit_ctl_t          ctl,
  output logic                        adv,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [kbt_pkg::DATA_W-1:0]  out_tdata,   // out_byte
  output logic                        out_tlast,   // last_out
  output logic                        out_tuser    // empty_end
);

  logic                       pad_seen_r, pad_seen_nxt;
  logic                       hold_v_r, hold_v_nxt;
  logic [kbt_pkg::DATA_W-1:0] hold_data_r, hold_data_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [kbt_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_empty_r, out_empty_nxt;
  logic [kbt_pkg::DATA_W-1:0] item_data;
  logic                       step, is_pad, kept, load;

  assign adv       = !out_valid_r || out_tready;
  assign step      = item.valid && adv;
  assign item_data = item.pad ? kbt_pkg::PAD_CHAR : item.data;
  assign is_pad    = (item_data == kbt_pkg::PAD_CHAR);
  assign kept      = !ctl.dec || (!pad_seen_r && !is_pad);

  always_comb begin
    pad_seen_nxt  = pad_seen_r;
    hold_v_nxt    = hold_v_r;
    hold_data_nxt = hold_data_r;
    load          = 1'b0;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    if (step) begin
      if (!item.is_end) begin
        if (ctl.dec && !pad_seen_r && is_pad) begin
          pad_seen_nxt = 1'b1;
        end
        if (kept) begin
          if (hold_v_r) begin
            load          = 1'b1;
            out_data_nxt  = hold_data_r;
            out_last_nxt  = 1'b0;
            out_empty_nxt = 1'b0;
          end
          hold_v_nxt    = 1'b1;
          hold_data_nxt = item_data;
        end
      end else begin
        if (hold_v_r) begin
          load          = 1'b1;
          out_data_nxt  = hold_data_r;
          out_last_nxt  = ctl.last_blk;
          out_empty_nxt = 1'b0;
        end else if (ctl.last_blk) begin
          load          = 1'b1;
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
        end
        hold_v_nxt = 1'b0;
        if (ctl.last_blk) begin
          pad_seen_nxt = 1'b0;
        end
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_seen_r  <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pad_seen_r  <= pad_seen_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hold_data_r <= hold_data_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule

FILE: rtl/core/keyed_block_transposition.sv
// Top level of the keyed block transposition: config registers, sequencer, two RAMs.
// Depends on kbt_pkg, kbt_ram, kbt_rank and kbt_emit.
//
// Bytes are collected into a block RAM one per cycle until L bytes (L the key length,
// 1 to 16) are in or the last byte arrives. The block is then closed: the rank unit
// computes one column rank per cycle and writes the permutation table RAM; the block
// is then read out through the table and the block RAM at one position per cycle
// while the result side does not stall. No input is taken while a block is ranked
// and read out. Short final blocks are padded with '&' on read; in decrypt mode
// everything from the first '&' of the message is dropped, and a message left with no
// byte ends in one result with empty_end set. Key, length and direction must be
// written between messages; the block itself does not enforce it.
module keyed_block_transposition (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [kbt_pkg::DATA_W-1:0]  in_tdata,    // data_byte
  input  logic                        in_tlast,    // last_in
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [kbt_pkg::DATA_W-1:0]  out_tdata,   // out_byte
  output logic                        out_tlast,   // last_out
  output logic                        out_tuser,   // empty_end
  input  logic                        cfg_we,
  input  logic [kbt_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [kbt_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int unsigned IW = kbt_pkg::IDX_W;
  localparam int unsigned CW = kbt_pkg::CNT_W;

  logic [kbt_pkg::LETTER_W-1:0]  key_len_r;
  logic [kbt_pkg::LETTERS_W-1:0] letters_lo_r;
  logic [kbt_pkg::LETTERS_W-1:0] letters_hi_r;
  logic                          dir_r;

  kbt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            last_blk_r, last_blk_nxt;
  logic            v1_r, v1_nxt, end1_r, end1_nxt;
  logic            v2_r, v2_nxt, end2_r, end2_nxt, pad2_r, pad2_nxt;

  logic [CW-1:0]   len;
  logic [CW-1:0]   fill_inc;
  logic            in_acc, blk_done, rank_phase, emit_phase, adv, issue, issue_rd;
  logic            emit_exit, rank_last;
  logic [IW-1:0]   rank;
  logic [IW-1:0]   tab_rd;
  logic [kbt_pkg::DATA_W-1:0] buf_rd;
  logic            tab_we;
  logic [IW-1:0]   tab_waddr, tab_wdata;

  kbt_pkg::emit_item_t item;
  kbt_pkg::emit_ctl_t  ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r    <= kbt_pkg::LETTER_W'(1);
      letters_lo_r <= '0;
      letters_hi_r <= '0;
      dir_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        kbt_pkg::CFG_KEY_LEN:    key_len_r    <= cfg_wdata[kbt_pkg::LETTER_W-1:0];
        kbt_pkg::CFG_LETTERS_LO: letters_lo_r <= cfg_wdata[kbt_pkg::LETTERS_W-1:0];
        kbt_pkg::CFG_LETTERS_HI: letters_hi_r <= cfg_wdata[kbt_pkg::LETTERS_W-1:0];
        kbt_pkg::CFG_DIRECTION:  dir_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_len_r == '0) begin
      len = CW'(1);
    end else if (key_len_r > kbt_pkg::LETTER_W'(kbt_pkg::MAX_KEY)) begin
      len = CW'(kbt_pkg::MAX_KEY);
    end else begin
      len = key_len_r[CW-1:0];
    end
  end

  assign in_acc    = in_tvalid && in_tready;
  assign fill_inc  = fill_r[CW-1] ? fill_r : fill_r + CW'(1);
  assign blk_done  = in_acc && (in_tlast || (fill_inc >= len));
  assign rank_last = (cnt_r == len - CW'(1));
  assign issue     = (cnt_r <= len);
  assign issue_rd  = emit_phase && adv && (cnt_r < len);
  assign emit_exit = emit_phase && adv && v2_r && end2_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kbt_pkg::ST_FILL: if (blk_done) state_nxt = kbt_pkg::ST_RANK;
      kbt_pkg::ST_RANK: if (rank_last) state_nxt = kbt_pkg::ST_EMIT;
      kbt_pkg::ST_EMIT: if (emit_exit) state_nxt = kbt_pkg::ST_FILL;
      default:          state_nxt = kbt_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    rank_phase = 1'b0;
    emit_phase = 1'b0;
    case (state_r)
      kbt_pkg::ST_FILL: in_tready  = 1'b1;
      kbt_pkg::ST_RANK: rank_phase = 1'b1;
      kbt_pkg::ST_EMIT: emit_phase = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    last_blk_nxt = last_blk_r;
    v1_nxt       = v1_r;
    end1_nxt     = end1_r;
    v2_nxt       = v2_r;
    end2_nxt     = end2_r;
    pad2_nxt     = pad2_r;
    if (in_acc) begin
      fill_nxt = fill_inc;
      if (blk_done) begin
        last_blk_nxt = in_tlast;
        cnt_nxt      = '0;
      end
    end
    if (rank_phase) begin
      cnt_nxt = rank_last ? '0 : cnt_r + CW'(1);
    end
    if (emit_phase && adv) begin
      v1_nxt   = issue;
      end1_nxt = (cnt_r == len);
      if (issue) begin
        cnt_nxt = cnt_r + CW'(1);
      end
      v2_nxt   = v1_r;
      end2_nxt = end1_r;
      pad2_nxt = ({1'b0, tab_rd} >= fill_r);
    end
    if (emit_exit) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kbt_pkg::ST_FILL;
      fill_r  <= '0;
      cnt_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
    end
    last_blk_r <= last_blk_nxt;
    end1_r     <= end1_nxt;
    end2_r     <= end2_nxt;
    pad2_r     <= pad2_nxt;
  end

  kbt_rank u_rank (
    .letters (({letters_hi_r, letters_lo_r})),
    .key_len (len),
    .idx     (cnt_r[IW-1:0]),
    .rank    (rank)
  );

  assign tab_we    = rank_phase;
  assign tab_waddr = dir_r ? cnt_r[IW-1:0] : rank;
  assign tab_wdata = dir_r ? rank : cnt_r[IW-1:0];

  kbt_ram #(.DW(IW), .AW(IW)) u_perm_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (issue_rd),
    .raddr (cnt_r[IW-1:0]),
    .rdata (tab_rd)
  );

  kbt_ram #(.DW(kbt_pkg::DATA_W), .AW(IW)) u_blk_buf (
    .clk   (clk),
    .we    (in_acc && !fill_r[CW-1]),
    .waddr (fill_r[IW-1:0]),
    .wdata (in_tdata),
    .re    (emit_phase && adv && v1_r && !end1_r),
    .raddr (tab_rd),
    .rdata (buf_rd)
  );

  assign item.valid  = emit_phase && v2_r;
  assign item.is_end = end2_r;
  assign item.pad    = pad2_r;
  assign item.data   = buf_rd;
  assign ctl.dec      = dir_r;
  assign ctl.last_blk = last_blk_r;

  kbt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .ctl        (ctl),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: tb/keyed_block_transposition_checker.sv
// Checker for the keyed block transposition: follows config writes and input beats,
// predicts the permuted output stream and compares every output beat against it.
// Depends on kbt_pkg for register indexes, widths and the pad byte.
module keyed_block_transposition_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [kbt_pkg::DATA_W-1:0]  in_tdata,
  input  logic                        in_tlast,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [kbt_pkg::DATA_W-1:0]  out_tdata,
  input  logic                        out_tlast,
  input  logic                        out_tuser,
  input  logic                        cfg_we,
  input  logic [kbt_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [kbt_pkg::CFG_DW-1:0]  cfg_wdata,
  output int                          mismatches,
  output int                          outstanding,
  output int                          beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import kbt_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              last;
    logic              empty;
  } cipher_beat_t;

  cipher_beat_t cipher_q[$];

  logic [4:0]                  key_len_q;
  logic [2*LETTERS_W-1:0]      letters_q;
  logic                        decrypt_q;
  logic [DATA_W-1:0]           block_bytes[MAX_KEY];
  int unsigned                 fill_cnt;
  logic                        trunc_seen;

  function automatic int unsigned block_len();
    if (key_len_q == 5'd0) return 1;
    if (key_len_q > MAX_KEY) return MAX_KEY;
    return key_len_q;
  endfunction

  function automatic int unsigned col_rank(input int unsigned j, input int unsigned len);
    int unsigned r;
    logic [LETTER_W-1:0] lj;
    logic [LETTER_W-1:0] li;
    r = 0;
    lj = letters_q[LETTER_W*j +: LETTER_W];
    for (int unsigned i = 0; i < len; i++) begin
      li = letters_q[LETTER_W*i +: LETTER_W];
      if (li < lj || (li == lj && i < j)) r++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: output beat %0d mismatch in %s: got %0h, want %0h",
             $time, beats_checked, what, got, want);
    mismatches++;
  endtask

  task automatic absorb_byte(input logic [DATA_W-1:0] b, input logic last);
    int unsigned len;
    int unsigned r;
    int unsigned cnt;
    logic [DATA_W-1:0] perm[MAX_KEY];
    cipher_beat_t beats[MAX_KEY];
    len = block_len();
    cnt = 0;
    if (fill_cnt < MAX_KEY) begin
      block_bytes[fill_cnt] = b;
      fill_cnt++;
    end
    if (!last && fill_cnt < len) return;
    for (int unsigned p = fill_cnt; p < len; p++) block_bytes[p] = PAD_CHAR;
    for (int unsigned p = 0; p < len; p++) begin
      r = col_rank(p, len);
      if (decrypt_q) perm[p] = block_bytes[r];
      else perm[r] = block_bytes[p];
    end
    for (int unsigned p = 0; p < len; p++) begin
      if (decrypt_q && (trunc_seen || perm[p] == PAD_CHAR)) begin
        trunc_seen = 1'b1;
      end else begin
        beats[cnt] = '{data: perm[p], last: 1'b0, empty: 1'b0};
        cnt++;
      end
    end
    if (last) begin
      if (cnt == 0) begin
        beats[0] = '{data: '0, last: 1'b1, empty: 1'b1};
        cnt = 1;
      end else begin
        beats[cnt-1].last = 1'b1;
      end
      trunc_seen = 1'b0;
    end
    for (int unsigned p = 0; p < cnt; p++) cipher_q.push_back(beats[p]);
    fill_cnt = 0;
  endtask

  task automatic check_beat();
    cipher_beat_t want;
    if (cipher_q.size() == 0) begin
      report_mismatch("data of a beat with nothing pending", out_tdata, '0);
      return;
    end
    want = cipher_q.pop_front();
    if (out_tdata !== want.data) report_mismatch("data", out_tdata, want.data);
    if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
    if (out_tuser !== want.empty) report_mismatch("empty_end", out_tuser, want.empty);
    beats_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_len_q = 5'd1;
      letters_q = '0;
      decrypt_q = 1'b0;
      fill_cnt = 0;
      trunc_seen = 1'b0;
      mismatches = 0;
      beats_checked = 0;
      cipher_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_beat();
      if (cfg_we) begin
        case (cfg_addr)
          CFG_KEY_LEN:    key_len_q = cfg_wdata[4:0];
          CFG_LETTERS_LO: letters_q[LETTERS_W-1:0] = cfg_wdata;
          CFG_LETTERS_HI: letters_q[2*LETTERS_W-1:LETTERS_W] = cfg_wdata;
          CFG_DIRECTION:  decrypt_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
    end
    outstanding <= cipher_q.size();
  end

endmodule

FILE: tb/keyed_block_transposition_test.sv
// Top of the keyed block transposition testbench: clock, reset, key setup and byte stimulus.
// Instantiates the block and keyed_block_transposition_checker; depends on kbt_pkg.
module keyed_block_transposition_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kbt_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_ITEMS = 240;
  localparam int SETTLE       = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam longint LIMIT_CYCLES = 300000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [DATA_W-1:0]   out_tdata;
  logic                out_tlast;
  logic                out_tuser;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;

  int mismatches;
  int outstanding;
  int beats_checked;

  bit quiet;
  bit hold_off_req;
  int items_sent;
  int messages_sent;
  int key_settings;

  always #(CLK_PERIOD/2) clk = ~clk;

  keyed_block_transposition dut (.*);

  keyed_block_transposition_checker checker_i (.*);

  task automatic set_key(input logic [4:0] len, input logic [2*LETTERS_W-1:0] letters,
                         input logic dir);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_KEY_LEN;
    cfg_wdata <= CFG_DW'(len);
    @(posedge clk);
    cfg_addr <= CFG_LETTERS_LO;
    cfg_wdata <= letters[LETTERS_W-1:0];
    @(posedge clk);
    cfg_addr <= CFG_LETTERS_HI;
    cfg_wdata <= letters[2*LETTERS_W-1:LETTERS_W];
    @(posedge clk);
    cfg_addr <= CFG_DIRECTION;
    cfg_wdata <= CFG_DW'(dir);
    @(posedge clk);
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
    if (!quiet && $urandom_range(99) < 3) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [DATA_W-1:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    messages_sent++;
  endtask

  task automatic send_message(input int n, input bit clean);
    logic [DATA_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = DATA_W'($urandom_range(255));
      if (!clean && $urandom_range(11) == 0) b = PAD_CHAR;
      else if (clean && b == PAD_CHAR) b = b ^ 8'h01;
      send_byte(b, i == n - 1);
    end
    messages_sent++;
  endtask

  // hold input idle until every expected beat is out, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [2*LETTERS_W-1:0] random_letters();
    logic [2*LETTERS_W-1:0] r;
    for (int i = 0; i < MAX_KEY; i++)
      r[LETTER_W*i +: LETTER_W] = LETTER_W'($urandom_range(9) == 0 ? $urandom_range(31)
                                                                   : $urandom_range(25));
    return r;
  endfunction

  function automatic logic [4:0] pick_len();
    case ($urandom_range(9))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'($urandom_range(17, 31));
      3: return 5'd1;
      default: return 5'($urandom_range(2, 6));
    endcase
  endfunction

  initial begin
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_KEY_LEN;
    cfg_wdata <= '0;
    out_tready <= 1'b0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= quiet || $urandom_range(99) >= 8;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [DATA_W-1:0]      msg[$];
    logic [2*LETTERS_W-1:0] letters;
    logic [4:0]             len;
    logic                   dir;
    int                     eff;
    int                     directed_items;
    bit                     stall_run;

    quiet = 1'b0;
    hold_off_req = 1'b0;
    items_sent = 0;
    messages_sent = 0;
    key_settings = 0;
    @(posedge clk iff rst_n);
    @(posedge clk);

    // reset key: single-byte blocks, encrypt
    msg = '{8'h00, 8'hFF};
    send_bytes(msg);
    drain();

    // zero length acts as one; a lone pad byte decrypts to an empty end
    set_key(5'd0, random_letters(), 1'b1);
    msg = '{PAD_CHAR};
    send_bytes(msg);
    drain();

    // length above the maximum, letters above Z, short padded decrypt block
    for (int i = 0; i < MAX_KEY; i++)
      letters[LETTER_W*i +: LETTER_W] = LETTER_W'($urandom_range(26, 31));
    set_key(5'd31, letters, 1'b1);
    msg = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45};
    send_bytes(msg);
    drain();

    // key CAB, encrypt with a padded final block
    letters = '0;
    letters[14:0] = {5'd1, 5'd0, 5'd2};
    set_key(5'd3, letters, 1'b0);
    msg = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h10};
    send_bytes(msg);
    drain();

    // tied letters, decrypt with a pad byte inside the first block
    for (int i = 0; i < MAX_KEY; i++) letters[LETTER_W*i +: LETTER_W] = 5'd7;
    set_key(5'd4, letters, 1'b1);
    msg = '{8'h30, 8'h31, PAD_CHAR, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};
    send_bytes(msg);
    drain();

    directed_items = items_sent;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      stall_run = (key_settings == 4);
      len = stall_run ? 5'd3 : pick_len();
      dir = 1'($urandom_range(1));
      eff = (len == 0) ? 1 : (len > MAX_KEY) ? MAX_KEY : len;
      set_key(len, random_letters(), dir);
      quiet = (key_settings == 6);
      if (stall_run) begin
        hold_off_req = 1'b1;
        send_message(10 * eff, dir);
      end else if (quiet) begin
        send_message(40, dir);
      end else begin
        repeat ($urandom_range(1, 3))
          send_message($urandom_range(1, 3 * eff), dir && $urandom_range(3) != 0);
      end
      drain();
    end
    quiet = 1'b0;

    $display("ran %0d messages, %0d bytes in and %0d beats out over %0d key settings",
             messages_sent, items_sent, beats_checked, key_settings);
    $display("key lengths 0 to 31, both directions, pad truncation and a long output stall");
    if (mismatches == 0 && outstanding == 0) begin
      $display("keyed_block_transposition_test: PASS");
    end else begin
      $display("keyed_block_transposition_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d beats still expected", outstanding);
    $display("keyed_block_transposition_test: FAIL");
    $finish;
  end

endmodule
